[rtl/core/jpeg_marker_segment_parser_defines.svh]
// Assertion macros for the JPEG marker segment parser
`ifndef JPEG_MARKER_SEGMENT_PARSER_DEFINES_SVH
`define JPEG_MARKER_SEGMENT_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define JMSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define JMSP_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define JMSP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define JMSP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[rtl/core/jmsp_pkg.sv]
// Types and constants shared by the JPEG marker segment parser
package jmsp_pkg;

    typedef enum logic [4:0] {
        M_HUNT     = 5'd0,
        M_MARK     = 5'd1,
        M_COM_HI   = 5'd2,
        M_COM_LO   = 5'd3,
        M_COM_BODY = 5'd4,
        M_DQT_HI   = 5'd5,
        M_DQT_LO   = 5'd6,
        M_DQT_HDR  = 5'd7,
        M_DQT_BODY = 5'd8,
        M_SOF_HI   = 5'd9,
        M_SOF_LO   = 5'd10,
        M_SOF_PREC = 5'd11,
        M_SOF_H_HI = 5'd12,
        M_SOF_H_LO = 5'd13,
        M_SOF_W_HI = 5'd14,
        M_SOF_W_LO = 5'd15,
        M_SOF_NC   = 5'd16,
        M_SOF_COMP = 5'd17,
        M_DHT_HI   = 5'd18,
        M_DHT_LO   = 5'd19,
        M_DHT_HDR  = 5'd20,
        M_DHT_CNT  = 5'd21,
        M_DHT_SYM  = 5'd22,
        M_SOS_HI   = 5'd23,
        M_SOS_LO   = 5'd24,
        M_SOS_NC   = 5'd25,
        M_SOS_COMP = 5'd26,
        M_SOS_SS   = 5'd27,
        M_SOS_SE   = 5'd28,
        M_SOS_A    = 5'd29,
        M_ENTROPY  = 5'd30
    } t_mode;

    typedef enum logic [4:0] {
        K_SOI        = 5'd0,
        K_EOI        = 5'd1,
        K_MARKER     = 5'd2,
        K_COMMENT    = 5'd3,
        K_QT_HDR     = 5'd4,
        K_QT_BYTE    = 5'd5,
        K_PRECISION  = 5'd6,
        K_HEIGHT     = 5'd7,
        K_WIDTH      = 5'd8,
        K_COMP_COUNT = 5'd9,
        K_COMP_ID    = 5'd10,
        K_SAMPLING   = 5'd11,
        K_QT_ID      = 5'd12,
        K_HUFF_HDR   = 5'd13,
        K_CODE_COUNT = 5'd14,
        K_SYMBOL     = 5'd15,
        K_SCAN_LEN   = 5'd16,
        K_SCAN_NC    = 5'd17,
        K_SCAN_ID    = 5'd18,
        K_TABLE_SEL  = 5'd19,
        K_SS         = 5'd20,
        K_SE         = 5'd21,
        K_APPROX     = 5'd22,
        K_ENTROPY    = 5'd23
    } t_kind;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_COM    = 8'hFE;
    localparam logic [7:0] MK_DQT    = 8'hDB;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_SOS    = 8'hDA;

    localparam logic [7:0] CODE_LENGTHS = 8'd16;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [15:0] value;
        logic [3:0]  nib_hi;
        logic [3:0]  nib_lo;
        logic [7:0]  index;
    } t_result;

endpackage

[rtl/core/jpeg_marker_segment_parser.sv]
// Top level of the JPEG marker segment parser
//
// Input channel: one file byte per item on i_data_byte, with i_file_start
// raised on the first byte of a new file to drop back to hunting for a
// marker before that byte is handled. Items move on i_in_valid/o_in_ready.
// Output channel: one tagged field per item on o_field_kind, o_field_value,
// o_nibble_high, o_nibble_low and o_item_index, moved on
// o_out_valid/i_out_ready. A byte yields zero or one field.
// A field is presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle while o_in_ready is high; the parse state updates in the same
// cycle the byte is taken, and one result register sits on the output.
// A byte that yields no field passes without touching the output.
// Stall: while a field waits in the result register and the receiver
// holds i_out_ready low, o_in_ready drops and the waiting field stays put.
// Reset: synchronous, active low; the parser hunts for 0xFF and the
// output register is empty.
module jpeg_marker_segment_parser
    import jmsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_field_kind,
    output logic [15:0] o_field_value,
    output logic [3:0]  o_nibble_high,
    output logic [3:0]  o_nibble_low,
    output logic [7:0]  o_item_index
);

    t_result step_res;
    t_result out_res;
    logic    accept;

    assign accept = i_in_valid && o_in_ready;

    jmsp_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_res        (step_res)
    );

    jmsp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_res       (step_res),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_field_kind  = out_res.kind;
    assign o_field_value = out_res.value;
    assign o_nibble_high = out_res.nib_hi;
    assign o_nibble_low  = out_res.nib_lo;
    assign o_item_index  = out_res.index;

endmodule

[rtl/core/jmsp_step.sv]
// Parser state registers and the per-byte next-state and field logic
`include "jpeg_marker_segment_parser_defines.svh"

module jmsp_step
    import jmsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_file_start,
    output t_result    o_res
);

    t_mode       r_mode,       n_mode;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [11:0] r_sym_total,  n_sym_total;
    logic [7:0]  r_hi_latch,   n_hi_latch;
    logic [7:0]  r_comp_cnt,   n_comp_cnt;
    logic [7:0]  r_comp_tot,   n_comp_tot;
    logic [1:0]  r_sub_pos,    n_sub_pos;

    t_mode       c_mode;
    logic [15:0] c_bytes_left;
    logic [11:0] c_sym_total;
    logic [7:0]  c_hi_latch;
    logic [7:0]  c_comp_cnt;
    logic [7:0]  c_comp_tot;
    logic [1:0]  c_sub_pos;
    logic [15:0] c_word;
    logic [11:0] c_sym_sum;
    logic [7:0]  c_cnt_inc;

    always_comb begin
        c_mode       = i_file_start ? M_HUNT : r_mode;
        c_bytes_left = i_file_start ? 16'd0 : r_bytes_left;
        c_sym_total  = i_file_start ? 12'd0 : r_sym_total;
        c_hi_latch   = i_file_start ? 8'd0 : r_hi_latch;
        c_comp_cnt   = i_file_start ? 8'd0 : r_comp_cnt;
        c_comp_tot   = i_file_start ? 8'd0 : r_comp_tot;
        c_sub_pos    = i_file_start ? 2'd0 : r_sub_pos;
        c_word       = {c_hi_latch, i_data_byte};
        c_sym_sum    = c_sym_total + {4'd0, i_data_byte};
        c_cnt_inc    = c_comp_cnt + 8'd1;
    end

    always_comb begin
        logic split;
        split         = 1'b0;
        n_mode        = c_mode;
        n_bytes_left  = c_bytes_left;
        n_sym_total   = c_sym_total;
        n_hi_latch    = c_hi_latch;
        n_comp_cnt    = c_comp_cnt;
        n_comp_tot    = c_comp_tot;
        n_sub_pos     = c_sub_pos;
        o_res.valid   = 1'b0;
        o_res.kind    = K_SOI;
        o_res.value   = {8'd0, i_data_byte};
        o_res.index   = 8'd0;
        case (c_mode)
            M_HUNT: begin
                if (i_data_byte == MK_PREFIX) begin
                    n_mode = M_MARK;
                end
            end
            M_MARK: begin
                n_mode = M_HUNT;
                case (i_data_byte)
                    MK_SOI: begin
                        o_res.valid = 1'b1;
                        o_res.kind  = K_SOI;
                    end
                    MK_EOI: begin
                        o_res.valid = 1'b1;
                        o_res.kind  = K_EOI;
                    end
                    MK_COM:  n_mode = M_COM_HI;
                    MK_DQT:  n_mode = M_DQT_HI;
                    MK_SOF0: n_mode = M_SOF_HI;
                    MK_DHT:  n_mode = M_DHT_HI;
                    MK_SOS:  n_mode = M_SOS_HI;
                    default: begin
                        o_res.valid = 1'b1;
                        o_res.kind  = K_MARKER;
                    end
                endcase
            end
            M_COM_HI: begin
                n_hi_latch = i_data_byte;
                n_mode     = M_COM_LO;
            end
            M_DQT_HI: begin
                n_hi_latch = i_data_byte;
                n_mode     = M_DQT_LO;
            end
            M_SOF_HI: begin
                n_hi_latch = i_data_byte;
                n_mode     = M_SOF_LO;
            end
            M_DHT_HI: begin
                n_hi_latch = i_data_byte;
                n_mode     = M_DHT_LO;
            end
            M_SOS_HI: begin
                n_hi_latch = i_data_byte;
                n_mode     = M_SOS_LO;
            end
            M_COM_LO: begin
                n_bytes_left = (c_word >= 16'd2) ? c_word - 16'd2 : 16'd0;
                n_mode       = (c_word > 16'd2) ? M_COM_BODY : M_HUNT;
            end
            M_COM_BODY: begin
                n_bytes_left = c_bytes_left - 16'd1;
                if (c_bytes_left == 16'd1) begin
                    n_mode = M_HUNT;
                end
                o_res.valid = 1'b1;
                o_res.kind  = K_COMMENT;
            end
            M_DQT_LO: begin
                n_bytes_left = (c_word >= 16'd3) ? c_word - 16'd3 : 16'd0;
                n_mode       = M_DQT_HDR;
            end
            M_DQT_HDR: begin
                n_mode      = (c_bytes_left != 16'd0) ? M_DQT_BODY : M_HUNT;
                o_res.valid = 1'b1;
                o_res.kind  = K_QT_HDR;
                split       = 1'b1;
            end
            M_DQT_BODY: begin
                n_bytes_left = c_bytes_left - 16'd1;
                if (c_bytes_left == 16'd1) begin
                    n_mode = M_HUNT;
                end
                o_res.valid = 1'b1;
                o_res.kind  = K_QT_BYTE;
            end
            M_SOF_LO: n_mode = M_SOF_PREC;
            M_SOF_PREC: begin
                n_mode      = M_SOF_H_HI;
                o_res.valid = 1'b1;
                o_res.kind  = K_PRECISION;
            end
            M_SOF_H_HI: begin
                n_hi_latch = i_data_byte;
                n_mode     = M_SOF_H_LO;
            end
            M_SOF_H_LO: begin
                n_mode      = M_SOF_W_HI;
                o_res.valid = 1'b1;
                o_res.kind  = K_HEIGHT;
                o_res.value = c_word;
            end
            M_SOF_W_HI: begin
                n_hi_latch = i_data_byte;
                n_mode     = M_SOF_W_LO;
            end
            M_SOF_W_LO: begin
                n_mode      = M_SOF_NC;
                o_res.valid = 1'b1;
                o_res.kind  = K_WIDTH;
                o_res.value = c_word;
            end
            M_SOF_NC: begin
                n_comp_tot  = i_data_byte;
                n_comp_cnt  = 8'd0;
                n_sub_pos   = 2'd0;
                n_mode      = (i_data_byte != 8'd0) ? M_SOF_COMP : M_HUNT;
                o_res.valid = 1'b1;
                o_res.kind  = K_COMP_COUNT;
            end
            M_SOF_COMP: begin
                o_res.valid = 1'b1;
                o_res.index = c_comp_cnt;
                if (c_sub_pos == 2'd0) begin
                    n_sub_pos  = 2'd1;
                    o_res.kind = K_COMP_ID;
                end else if (c_sub_pos == 2'd1) begin
                    n_sub_pos  = 2'd2;
                    o_res.kind = K_SAMPLING;
                    split      = 1'b1;
                end else begin
                    n_sub_pos  = 2'd0;
                    n_comp_cnt = c_cnt_inc;
                    if (c_cnt_inc == c_comp_tot) begin
                        n_mode = M_HUNT;
                    end
                    o_res.kind = K_QT_ID;
                end
            end
            M_DHT_LO: n_mode = M_DHT_HDR;
            M_DHT_HDR: begin
                n_comp_cnt  = 8'd0;
                n_sym_total = 12'd0;
                n_mode      = M_DHT_CNT;
                o_res.valid = 1'b1;
                o_res.kind  = K_HUFF_HDR;
                split       = 1'b1;
            end
            M_DHT_CNT: begin
                n_sym_total = c_sym_sum;
                n_comp_cnt  = c_cnt_inc;
                if (c_cnt_inc >= CODE_LENGTHS) begin
                    n_mode = (c_sym_sum != 12'd0) ? M_DHT_SYM : M_HUNT;
                end
                o_res.valid = 1'b1;
                o_res.kind  = K_CODE_COUNT;
                o_res.index = c_cnt_inc;
            end
            M_DHT_SYM: begin
                n_sym_total = c_sym_total - 12'd1;
                if (c_sym_total == 12'd1) begin
                    n_mode = M_HUNT;
                end
                o_res.valid = 1'b1;
                o_res.kind  = K_SYMBOL;
            end
            M_SOS_LO: begin
                n_mode      = M_SOS_NC;
                o_res.valid = 1'b1;
                o_res.kind  = K_SCAN_LEN;
                o_res.value = c_word;
            end
            M_SOS_NC: begin
                n_comp_tot  = i_data_byte;
                n_comp_cnt  = 8'd0;
                n_sub_pos   = 2'd0;
                n_mode      = (i_data_byte != 8'd0) ? M_SOS_COMP : M_SOS_SS;
                o_res.valid = 1'b1;
                o_res.kind  = K_SCAN_NC;
            end
            M_SOS_COMP: begin
                o_res.valid = 1'b1;
                o_res.index = c_comp_cnt;
                if (c_sub_pos == 2'd0) begin
                    n_sub_pos  = 2'd1;
                    o_res.kind = K_SCAN_ID;
                end else begin
                    n_sub_pos  = 2'd0;
                    n_comp_cnt = c_cnt_inc;
                    if (c_cnt_inc == c_comp_tot) begin
                        n_mode = M_SOS_SS;
                    end
                    o_res.kind = K_TABLE_SEL;
                    split      = 1'b1;
                end
            end
            M_SOS_SS: begin
                n_mode      = M_SOS_SE;
                o_res.valid = 1'b1;
                o_res.kind  = K_SS;
            end
            M_SOS_SE: begin
                n_mode      = M_SOS_A;
                o_res.valid = 1'b1;
                o_res.kind  = K_SE;
            end
            M_SOS_A: begin
                n_mode      = M_ENTROPY;
                o_res.valid = 1'b1;
                o_res.kind  = K_APPROX;
                split       = 1'b1;
            end
            M_ENTROPY: begin
                o_res.valid = 1'b1;
                o_res.kind  = K_ENTROPY;
            end
            default: n_mode = M_HUNT;
        endcase
        o_res.nib_hi = split ? i_data_byte[7:4] : 4'd0;
        o_res.nib_lo = split ? i_data_byte[3:0] : 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_HUNT;
            r_bytes_left <= 16'd0;
            r_sym_total  <= 12'd0;
            r_hi_latch   <= 8'd0;
            r_comp_cnt   <= 8'd0;
            r_comp_tot   <= 8'd0;
            r_sub_pos    <= 2'd0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_bytes_left <= n_bytes_left;
            r_sym_total  <= n_sym_total;
            r_hi_latch   <= n_hi_latch;
            r_comp_cnt   <= n_comp_cnt;
            r_comp_tot   <= n_comp_tot;
            r_sub_pos    <= n_sub_pos;
        end
    end

    `JMSP_ASSERT_IMPL(a_entropy_emits, i_clk, i_rst_n,
        i_accept && !i_file_start && r_mode == M_ENTROPY,
        o_res.valid && o_res.kind == K_ENTROPY)
    `JMSP_ASSERT_NEVER(a_hunt_silent, i_clk, i_rst_n,
        i_accept && (i_file_start || r_mode == M_HUNT) && o_res.valid)
    `JMSP_ASSERT_IMPL(a_nibbles_split_only, i_clk, i_rst_n,
        o_res.valid && !(o_res.kind == K_QT_HDR || o_res.kind == K_SAMPLING ||
            o_res.kind == K_HUFF_HDR || o_res.kind == K_TABLE_SEL ||
            o_res.kind == K_APPROX),
        o_res.nib_hi == 4'd0 && o_res.nib_lo == 4'd0)
    `JMSP_ASSERT_IMPL(a_index_kinds, i_clk, i_rst_n,
        o_res.valid && o_res.index != 8'd0,
        o_res.kind == K_COMP_ID || o_res.kind == K_SAMPLING ||
            o_res.kind == K_QT_ID || o_res.kind == K_CODE_COUNT ||
            o_res.kind == K_SCAN_ID || o_res.kind == K_TABLE_SEL)

endmodule

[rtl/core/jmsp_out_reg.sv]
// Result register that holds one field item toward the receiver
module jmsp_out_reg
    import jmsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_result i_res,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;
    logic    load;

    assign o_in_ready  = !r_valid || i_out_ready;
    assign load        = i_in_valid && o_in_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= load && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_res.valid) begin
            r_res <= i_res;
        end
    end

endmodule

[tb/sv/jpeg_marker_segment_parser_tb.sv]
// Self-checking testbench for the JPEG marker segment parser
`timescale 1ns / 100ps

module jpeg_marker_segment_parser_tb;
    import jmsp_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] value;
        logic [3:0]  nib_hi;
        logic [3:0]  nib_lo;
        logic [7:0]  index;
    } field_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_file_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [4:0]  o_field_kind;
    logic [15:0] o_field_value;
    logic [3:0]  o_nibble_high;
    logic [3:0]  o_nibble_low;
    logic [7:0]  o_item_index;

    field_t      fields_due[$];
    logic [7:0]  file_bytes[$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    logic        idle_on = 1'b1;
    int          stall_req = 0;
    int          stall_len = 0;
    int          stall_ack = 0;
    int          rx_hold = 0;
    int          rx_gap;
    field_t      rx_seen;
    field_t      rx_want;

    t_mode       pm_mode = M_HUNT;
    logic [15:0] pm_bytes_left = '0;
    logic [11:0] pm_symbols_left = '0;
    logic [7:0]  pm_high_byte = '0;
    logic [7:0]  pm_comp_index = '0;
    logic [7:0]  pm_comp_total = '0;
    logic [2:0]  pm_sub_pos = '0;

    jpeg_marker_segment_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_file_start  (i_file_start),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_field_kind  (o_field_kind),
        .o_field_value (o_field_value),
        .o_nibble_high (o_nibble_high),
        .o_nibble_low  (o_nibble_low),
        .o_item_index  (o_item_index)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic void push_field(t_kind k, logic [15:0] v, bit split, logic [7:0] idx);
        field_t f;
        f.kind   = k;
        f.value  = v;
        f.nib_hi = split ? v[7:4] : 4'h0;
        f.nib_lo = split ? v[3:0] : 4'h0;
        f.index  = idx;
        fields_due.push_back(f);
    endfunction

    function automatic void predict_fields(logic [7:0] b, logic start);
        logic [15:0] word;
        logic [15:0] bv;
        logic [7:0]  idx;
        if (start) begin
            pm_mode         = M_HUNT;
            pm_bytes_left   = '0;
            pm_symbols_left = '0;
            pm_high_byte    = '0;
            pm_comp_index   = '0;
            pm_comp_total   = '0;
            pm_sub_pos      = '0;
        end
        word = {pm_high_byte, b};
        bv   = {8'd0, b};
        case (pm_mode)
            M_HUNT: begin
                if (b == MK_PREFIX) pm_mode = M_MARK;
            end
            M_MARK: begin
                pm_mode = M_HUNT;
                case (b)
                    MK_SOI:  push_field(K_SOI, bv, 1'b0, 8'd0);
                    MK_EOI:  push_field(K_EOI, bv, 1'b0, 8'd0);
                    MK_COM:  pm_mode = M_COM_HI;
                    MK_DQT:  pm_mode = M_DQT_HI;
                    MK_SOF0: pm_mode = M_SOF_HI;
                    MK_DHT:  pm_mode = M_DHT_HI;
                    MK_SOS:  pm_mode = M_SOS_HI;
                    default: push_field(K_MARKER, bv, 1'b0, 8'd0);
                endcase
            end
            M_COM_HI, M_DQT_HI, M_SOF_HI, M_DHT_HI, M_SOS_HI, M_SOF_H_HI, M_SOF_W_HI: begin
                pm_high_byte = b;
                pm_mode = t_mode'(pm_mode + 5'd1);
            end
            M_COM_LO: begin
                pm_bytes_left = (word >= 16'd2) ? word - 16'd2 : 16'd0;
                pm_mode = (pm_bytes_left != 0) ? M_COM_BODY : M_HUNT;
            end
            M_COM_BODY: begin
                pm_bytes_left--;
                if (pm_bytes_left == 0) pm_mode = M_HUNT;
                push_field(K_COMMENT, bv, 1'b0, 8'd0);
            end
            M_DQT_LO: begin
                pm_bytes_left = (word >= 16'd3) ? word - 16'd3 : 16'd0;
                pm_mode = M_DQT_HDR;
            end
            M_DQT_HDR: begin
                pm_mode = (pm_bytes_left != 0) ? M_DQT_BODY : M_HUNT;
                push_field(K_QT_HDR, bv, 1'b1, 8'd0);
            end
            M_DQT_BODY: begin
                pm_bytes_left--;
                if (pm_bytes_left == 0) pm_mode = M_HUNT;
                push_field(K_QT_BYTE, bv, 1'b0, 8'd0);
            end
            M_SOF_LO: pm_mode = M_SOF_PREC;
            M_SOF_PREC: begin
                pm_mode = M_SOF_H_HI;
                push_field(K_PRECISION, bv, 1'b0, 8'd0);
            end
            M_SOF_H_LO: begin
                pm_mode = M_SOF_W_HI;
                push_field(K_HEIGHT, word, 1'b0, 8'd0);
            end
            M_SOF_W_LO: begin
                pm_mode = M_SOF_NC;
                push_field(K_WIDTH, word, 1'b0, 8'd0);
            end
            M_SOF_NC: begin
                pm_comp_total = b;
                pm_comp_index = '0;
                pm_sub_pos    = '0;
                pm_mode = (b != 0) ? M_SOF_COMP : M_HUNT;
                push_field(K_COMP_COUNT, bv, 1'b0, 8'd0);
            end
            M_SOF_COMP: begin
                idx = pm_comp_index;
                if (pm_sub_pos == 3'd0) begin
                    pm_sub_pos = 3'd1;
                    push_field(K_COMP_ID, bv, 1'b0, idx);
                end else if (pm_sub_pos == 3'd1) begin
                    pm_sub_pos = 3'd2;
                    push_field(K_SAMPLING, bv, 1'b1, idx);
                end else begin
                    pm_sub_pos = 3'd0;
                    pm_comp_index++;
                    if (pm_comp_index == pm_comp_total) pm_mode = M_HUNT;
                    push_field(K_QT_ID, bv, 1'b0, idx);
                end
            end
            M_DHT_LO: pm_mode = M_DHT_HDR;
            M_DHT_HDR: begin
                pm_comp_index   = '0;
                pm_symbols_left = '0;
                pm_mode = M_DHT_CNT;
                push_field(K_HUFF_HDR, bv, 1'b1, 8'd0);
            end
            M_DHT_CNT: begin
                idx = pm_comp_index + 8'd1;
                pm_symbols_left = pm_symbols_left + b;
                pm_comp_index++;
                if (pm_comp_index >= CODE_LENGTHS)
                    pm_mode = (pm_symbols_left != 0) ? M_DHT_SYM : M_HUNT;
                push_field(K_CODE_COUNT, bv, 1'b0, idx);
            end
            M_DHT_SYM: begin
                pm_symbols_left--;
                if (pm_symbols_left == 0) pm_mode = M_HUNT;
                push_field(K_SYMBOL, bv, 1'b0, 8'd0);
            end
            M_SOS_LO: begin
                pm_mode = M_SOS_NC;
                push_field(K_SCAN_LEN, word, 1'b0, 8'd0);
            end
            M_SOS_NC: begin
                pm_comp_total = b;
                pm_comp_index = '0;
                pm_sub_pos    = '0;
                pm_mode = (b != 0) ? M_SOS_COMP : M_SOS_SS;
                push_field(K_SCAN_NC, bv, 1'b0, 8'd0);
            end
            M_SOS_COMP: begin
                idx = pm_comp_index;
                if (pm_sub_pos == 3'd0) begin
                    pm_sub_pos = 3'd1;
                    push_field(K_SCAN_ID, bv, 1'b0, idx);
                end else begin
                    pm_sub_pos = 3'd0;
                    pm_comp_index++;
                    if (pm_comp_index == pm_comp_total) pm_mode = M_SOS_SS;
                    push_field(K_TABLE_SEL, bv, 1'b1, idx);
                end
            end
            M_SOS_SS: begin
                pm_mode = M_SOS_SE;
                push_field(K_SS, bv, 1'b0, 8'd0);
            end
            M_SOS_SE: begin
                pm_mode = M_SOS_A;
                push_field(K_SE, bv, 1'b0, 8'd0);
            end
            M_SOS_A: begin
                pm_mode = M_ENTROPY;
                push_field(K_APPROX, bv, 1'b1, 8'd0);
            end
            M_ENTROPY: push_field(K_ENTROPY, bv, 1'b0, 8'd0);
            default: pm_mode = M_HUNT;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                rx_seen = {o_field_kind, o_field_value, o_nibble_high, o_nibble_low,
                           o_item_index};
                if (fields_due.size() == 0) begin
                    $display("%0t: unexpected field: kind %0d value %h", $time,
                             o_field_kind, o_field_value);
                    mismatch_count++;
                end else begin
                    rx_want = fields_due.pop_front();
                    if (rx_seen !== rx_want) begin
                        $display("%0t: expected kind %0d value %h hi %h lo %h index %0d",
                                 $time, rx_want.kind, rx_want.value, rx_want.nib_hi,
                                 rx_want.nib_lo, rx_want.index);
                        $display("%0t:   actual kind %0d value %h hi %h lo %h index %0d",
                                 $time, o_field_kind, o_field_value, o_nibble_high,
                                 o_nibble_low, o_item_index);
                        mismatch_count++;
                    end
                end
            end
            if (stall_req != stall_ack) begin
                stall_ack = stall_req;
                rx_hold   = stall_len;
            end
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                rx_hold--;
            end else begin
                rx_gap = pick_gap();
                if (rx_gap == 0) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    rx_hold = rx_gap - 1;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_file_start <= s;
        do @(posedge i_clk); while (!o_in_ready);
        predict_fields(b, s);
        bytes_sent++;
    endtask

    task automatic wait_fields_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (fields_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_file(input logic first_start);
        foreach (file_bytes[i]) send_byte(file_bytes[i], (i == 0) ? first_start : 1'b0);
        file_bytes.delete();
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void put_marker(logic [7:0] code);
        file_bytes.push_back(MK_PREFIX);
        file_bytes.push_back(code);
    endfunction

    function automatic void put_word(logic [15:0] w);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[7:0]);
    endfunction

    function automatic void put_random(int n);
        for (int i = 0; i < n; i++)
            file_bytes.push_back(($urandom_range(0, 7) == 0) ? MK_PREFIX : rand_byte());
    endfunction

    function automatic void put_com(logic [15:0] len);
        put_marker(MK_COM);
        put_word(len);
        put_random((len > 2) ? int'(len) - 2 : 0);
    endfunction

    function automatic void put_dqt(logic [15:0] len);
        put_marker(MK_DQT);
        put_word(len);
        file_bytes.push_back(rand_byte());
        put_random((len > 3) ? int'(len) - 3 : 0);
    endfunction

    function automatic void put_sof(logic [7:0] nc, logic [15:0] h, logic [15:0] w);
        put_marker(MK_SOF0);
        put_word(16'($urandom));
        file_bytes.push_back(rand_byte());
        put_word(h);
        put_word(w);
        file_bytes.push_back(nc);
        put_random(3 * int'(nc));
    endfunction

    function automatic void put_dht(int max_count);
        int total;
        int r;
        logic [7:0] c;
        total = 0;
        put_marker(MK_DHT);
        put_word(16'($urandom));
        file_bytes.push_back(rand_byte());
        for (int i = 0; i < 16; i++) begin
            r = $urandom_range(0, 99);
            if (max_count == 0 || r < 60) c = 8'd0;
            else if (r < 97) c = 8'($urandom_range(1, max_count));
            else c = rand_byte();
            file_bytes.push_back(c);
            total += c;
        end
        put_random(total);
    endfunction

    function automatic void put_sos(logic [7:0] nc, int entropy_len);
        put_marker(MK_SOS);
        put_word(16'($urandom));
        file_bytes.push_back(nc);
        put_random(2 * int'(nc) + 3);
        put_random(entropy_len);
    endfunction

    task automatic test_markers();
        file_bytes = '{8'h12, MK_PREFIX, MK_SOI, MK_PREFIX, MK_EOI, MK_PREFIX, 8'h00,
                       MK_PREFIX, MK_PREFIX, MK_PREFIX, 8'h01, 8'h7F};
        send_file(1'b1);
        wait_fields_drained();
    endtask

    task automatic test_comment_segments();
        put_com(16'd0);
        put_com(16'd1);
        put_com(16'd2);
        put_com(16'd5);
        send_file(1'b0);
        wait_fields_drained();
    endtask

    task automatic test_quant_tables();
        put_dqt(16'd0);
        put_dqt(16'd3);
        put_dqt(16'd6);
        send_file(1'b0);
        wait_fields_drained();
    endtask

    task automatic test_frame_headers();
        put_sof(8'd0, 16'hFFFF, 16'h0000);
        put_sof(8'd1, 16'h0000, 16'hFFFF);
        put_sof(8'd3, 16'($urandom), 16'($urandom));
        send_file(1'b0);
        wait_fields_drained();
    endtask

    task automatic test_huffman_tables();
        put_dht(0);
        put_dht(3);
        send_file(1'b0);
        wait_fields_drained();
    endtask

    task automatic test_restart_mid_segment();
        put_sof(8'd3, 16'h1234, 16'h5678);
        repeat (5) void'(file_bytes.pop_back());
        send_file(1'b0);
        put_marker(MK_SOI);
        put_marker(MK_EOI);
        send_file(1'b1);
        wait_fields_drained();
    endtask

    task automatic test_scan_and_entropy();
        put_sos(8'd0, 3);
        put_marker(MK_EOI);
        put_marker(MK_SOI);
        send_file(1'b0);
        put_marker(MK_SOI);
        put_sos(8'd2, 5);
        send_file(1'b1);
        put_marker(MK_EOI);
        send_file(1'b1);
        wait_fields_drained();
    endtask

    task automatic test_output_backpressure();
        idle_on   <= 1'b0;
        stall_len <= 150;
        stall_req <= stall_req + 1;
        put_marker(MK_SOI);
        put_com(16'd60);
        send_file(1'b1);
        wait_fields_drained();
        idle_on <= 1'b1;
        wait_fields_drained();
    endtask

    task automatic build_random_file();
        int nseg;
        int r;
        if ($urandom_range(0, 9) != 0) put_marker(MK_SOI);
        nseg = $urandom_range(0, 4);
        for (int i = 0; i < nseg; i++) begin
            case ($urandom_range(0, 5))
                0: put_com(($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1))
                                                      : 16'($urandom_range(2, 14)));
                1: put_dqt(16'($urandom_range(0, 20)));
                2: put_sof(($urandom_range(0, 49) == 0) ? 8'($urandom_range(5, 255))
                                                       : 8'($urandom_range(0, 4)),
                           16'($urandom), 16'($urandom));
                3: put_dht(4);
                4: put_marker(rand_byte());
                default: put_random($urandom_range(1, 6));
            endcase
        end
        r = $urandom_range(0, 9);
        if (r < 5) put_sos(8'($urandom_range(0, 4)), $urandom_range(0, 24));
        else if (r < 8) put_marker(MK_EOI);
        else if (file_bytes.size() > 2)
            repeat ($urandom_range(1, file_bytes.size() - 1)) void'(file_bytes.pop_back());
    endtask

    task automatic test_random_files();
        int target;
        target = bytes_sent + 1580;
        while (bytes_sent < target) begin
            idle_on <= ($urandom_range(0, 4) != 0);
            build_random_file();
            send_file(($urandom_range(0, 9) != 0) ? 1'b1 : 1'b0);
            if ($urandom_range(0, 9) == 0) wait_fields_drained();
        end
        idle_on <= 1'b1;
        wait_fields_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_markers();
        test_comment_segments();
        test_quant_tables();
        test_frame_headers();
        test_huffman_tables();
        test_restart_mid_segment();
        test_scan_and_entropy();
        test_output_backpressure();
        test_random_files();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && fields_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/jmsp_pkg.sv
rtl/core/jmsp_step.sv
rtl/core/jmsp_out_reg.sv
rtl/core/jpeg_marker_segment_parser.sv
tb/sv/jpeg_marker_segment_parser_tb.sv
